FILE: hw/rtl/sms_pkg.sv
// Shared types and constants for the set statistics block.
// No dependencies; every other file takes its names from here.
`default_nettype none
package sms_pkg;

    // Field and accumulator widths
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned SUM_W    = 36;
    localparam int unsigned SQSUM_W  = 60;
    localparam int unsigned SQ_W     = 47;   // square of one sample
    localparam int unsigned WIDE_W   = 72;   // n*Q and S*S
    localparam int unsigned DIVR_W   = 24;   // divisor n*(n-1)
    localparam int unsigned ROOT_W   = 64;
    localparam int unsigned STEP_W   = 7;

    // Saturation point of the sample count
    localparam int unsigned MAX_COUNT = 4096;

    // Queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_LVL_W = $clog2(Q_DEPTH + 1);

    // Iteration counts of the serial units
    localparam int unsigned MUL_STEPS  = 36;
    localparam int unsigned DIV_STEPS  = 72;
    localparam int unsigned SQRT_STEPS = 32;

    localparam logic [ROOT_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [SAMPLE_W-1:0]        t_udev;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [SUM_W-1:0]           t_mag;
    typedef logic [SQSUM_W-1:0]         t_sqsum;
    typedef logic [SQ_W-1:0]            t_square;
    typedef logic [WIDE_W-1:0]          t_wide;
    typedef logic [DIVR_W-1:0]          t_divisor;
    typedef logic [ROOT_W-1:0]          t_root;
    typedef logic [STEP_W-1:0]          t_step;
    typedef logic [Q_PTR_W-1:0]         t_qptr;
    typedef logic [Q_LVL_W-1:0]         t_level;
    typedef logic [Q_LVL_W:0]           t_pend;

    // Totals of one closed set
    typedef struct packed {
        t_count  count;
        t_sum    sum;
        t_sqsum  sq_sum;
        t_sample maximum;
        t_sample minimum;
        logic    overflow;
    } t_set_sums;

    typedef struct packed {
        logic      valid;
        t_set_sums data;
    } t_push;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL_NQ,
        BK_MUL_SS,
        BK_SUB,
        BK_DIV_VAR,
        BK_SQRT,
        BK_MEAN_SETUP,
        BK_DIV_MEAN,
        BK_FINISH
    } t_back_state;

endpackage
`default_nettype wire

FILE: hw/rtl/sms_in_if.sv
// Input channel: one sample item per transfer.
// Depends on sms_pkg.
`default_nettype none
interface sms_in_if;
    logic             valid;
    logic             ready;
    sms_pkg::t_sample sample;
    logic             has_value;
    logic             last;

    modport source (output valid, sample, has_value, last, input ready);
    modport sink   (input valid, sample, has_value, last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sms_out_if.sv
// Output channel: one statistics result per transfer.
// Depends on sms_pkg.
`default_nettype none
interface sms_out_if;
    logic             valid;
    logic             ready;
    sms_pkg::t_count  count;
    sms_pkg::t_sample mean;
    sms_pkg::t_udev   std_dev;
    sms_pkg::t_sample maximum;
    sms_pkg::t_sample minimum;
    logic             overflow;

    modport source (output valid, count, mean, std_dev, maximum, minimum, overflow,
                    input ready);
    modport sink   (input valid, count, mean, std_dev, maximum, minimum, overflow,
                    output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sms_front.sv
// Front end: takes sample items, keeps count, sum, max, min and sum of squares,
// and pushes the totals of each closed set into the queue. Depends on sms_pkg, sms_in_if.
`default_nettype none
module sms_front #(
    parameter int unsigned MAX_COUNT = sms_pkg::MAX_COUNT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sms_in_if.sink          i_in,
    input  sms_pkg::t_level i_q_level,
    output sms_pkg::t_push  o_push
);

    localparam sms_pkg::t_count MAX_C = sms_pkg::t_count'(MAX_COUNT);

    sms_pkg::t_count  r_count, n_count;
    sms_pkg::t_sum    r_sum, n_sum;
    sms_pkg::t_sample r_max, n_max;
    sms_pkg::t_sample r_min, n_min;
    logic             r_ovf, n_ovf;
    sms_pkg::t_sqsum  r_sq_sum;
    sms_pkg::t_square r_sq;
    logic             r_sq_add;
    logic             r_close;

    // snapshot of a closing set, waiting for its last square
    sms_pkg::t_count  r_cl_count;
    sms_pkg::t_sum    r_cl_sum;
    sms_pkg::t_sample r_cl_max;
    sms_pkg::t_sample r_cl_min;
    logic             r_cl_ovf;

    logic             acc;
    logic             take;
    logic             hit;
    sms_pkg::t_sample v;
    logic signed [2*sms_pkg::SAMPLE_W-1:0] sq_full;
    sms_pkg::t_sqsum  sq_tot;
    sms_pkg::t_pend   pend;

    assign v    = i_in.sample;
    assign acc  = i_in.valid & i_in.ready;
    assign take = i_in.has_value & (r_count < MAX_C);
    assign hit  = i_in.has_value & ~(r_count < MAX_C);

    // room for the push a pending close will make
    assign pend       = sms_pkg::t_pend'(i_q_level) + sms_pkg::t_pend'(r_close);
    assign i_in.ready = pend < sms_pkg::t_pend'(sms_pkg::Q_DEPTH);

    // next running totals
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_max   = r_max;
        n_min   = r_min;
        n_ovf   = r_ovf | hit;
        if (take) begin
            n_count = r_count + 1'b1;
            n_sum   = r_sum + sms_pkg::t_sum'(v);
            if (r_count == '0) begin
                n_max = v;
                n_min = v;
            end else begin
                if (v > r_max) n_max = v;
                if (v < r_min) n_min = v;
            end
        end
    end

    // square is registered, then folded into the sum in the next cycle
    assign sq_full = v * v;
    assign sq_tot  = r_sq_sum + (r_sq_add ? sms_pkg::t_sqsum'(r_sq) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_max    <= '0;
            r_min    <= '0;
            r_ovf    <= 1'b0;
            r_sq_sum <= '0;
            r_sq_add <= 1'b0;
            r_close  <= 1'b0;
        end else begin
            r_sq_add <= acc & take;
            r_close  <= acc & i_in.last;
            if (acc) begin
                if (i_in.last) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_max   <= '0;
                    r_min   <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_max   <= n_max;
                    r_min   <= n_min;
                    r_ovf   <= n_ovf;
                end
            end
            r_sq_sum <= r_close ? '0 : sq_tot;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sq <= sq_full[sms_pkg::SQ_W-1:0];
        if (acc && i_in.last) begin
            r_cl_count <= n_count;
            r_cl_sum   <= n_sum;
            r_cl_max   <= n_max;
            r_cl_min   <= n_min;
            r_cl_ovf   <= n_ovf;
        end
    end

    always_comb begin
        o_push.valid         = r_close;
        o_push.data.count    = r_cl_count;
        o_push.data.sum      = r_cl_sum;
        o_push.data.sq_sum   = sq_tot;
        o_push.data.maximum  = r_cl_max;
        o_push.data.minimum  = r_cl_min;
        o_push.data.overflow = r_cl_ovf;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sms_queue.sv
// Short queue of closed-set totals between front and back end.
// Depends on sms_pkg.
`default_nettype none
module sms_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sms_pkg::t_push     i_push,
    input  logic               i_pop,
    output sms_pkg::t_set_sums o_head,
    output logic               o_head_valid,
    output sms_pkg::t_level    o_level
);

    localparam sms_pkg::t_qptr LAST_PTR = sms_pkg::t_qptr'(sms_pkg::Q_DEPTH - 1);

    sms_pkg::t_set_sums r_mem [sms_pkg::Q_DEPTH];
    sms_pkg::t_qptr     r_wr;
    sms_pkg::t_qptr     r_rd;
    sms_pkg::t_level    r_level;
    logic               pop_ok;

    assign pop_ok       = i_pop & (r_level != '0);
    assign o_head       = r_mem[r_rd];
    assign o_head_valid = r_level != '0;
    assign o_level      = r_level;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push.valid) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            if (pop_ok)       r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            case ({i_push.valid, pop_ok})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_mem[r_wr] <= i_push.data;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sms_back.sv
// Back end: turns the totals of one set into mean and standard deviation with
// a shift-add multiplier, a restoring divider and a bit-pair square root. Depends on sms_pkg.
`default_nettype none
module sms_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sms_pkg::t_set_sums i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    sms_out_if.source          o_out
);

    localparam sms_pkg::t_step MUL_END  = sms_pkg::t_step'(sms_pkg::MUL_STEPS - 1);
    localparam sms_pkg::t_step DIV_END  = sms_pkg::t_step'(sms_pkg::DIV_STEPS - 1);
    localparam sms_pkg::t_step SQRT_END = sms_pkg::t_step'(sms_pkg::SQRT_STEPS - 1);
    localparam int unsigned    DW       = sms_pkg::DIVR_W;
    localparam int unsigned    WW       = sms_pkg::WIDE_W;
    localparam int unsigned    RW       = sms_pkg::ROOT_W;
    localparam int unsigned    SW       = sms_pkg::SAMPLE_W;

    sms_pkg::t_back_state r_state, n_state;
    sms_pkg::t_set_sums   r_set, n_set;
    sms_pkg::t_step       r_step, n_step;
    sms_pkg::t_wide       r_mul_acc, n_mul_acc;
    sms_pkg::t_wide       r_mul_a, n_mul_a;
    sms_pkg::t_mag        r_mul_b, n_mul_b;
    sms_pkg::t_wide       r_nq, n_nq;
    sms_pkg::t_divisor    r_div_rem, n_div_rem;
    sms_pkg::t_wide       r_div_quo, n_div_quo;
    sms_pkg::t_divisor    r_divisor, n_divisor;
    sms_pkg::t_root       r_sq_v, n_sq_v;
    sms_pkg::t_root       r_sq_res, n_sq_res;
    sms_pkg::t_root       r_sq_bit, n_sq_bit;
    sms_pkg::t_udev       r_sd, n_sd;
    sms_pkg::t_sample     r_mean, n_mean;
    logic                 r_out_valid, n_out_valid;
    logic                 load_out;

    sms_pkg::t_count  out_count;
    sms_pkg::t_sample out_mean;
    sms_pkg::t_udev   out_sd;
    sms_pkg::t_sample out_max;
    sms_pkg::t_sample out_min;
    logic             out_ovf;

    // serial step logic
    logic             sum_neg;
    sms_pkg::t_mag    abs_sum;
    sms_pkg::t_wide   mul_sum;
    sms_pkg::t_wide   mul_acc_step;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_diff;
    logic             div_ge;
    sms_pkg::t_divisor div_rem_step;
    sms_pkg::t_wide   div_quo_step;
    sms_pkg::t_root   sq_trial;
    logic             sq_ge;
    sms_pkg::t_root   sq_v_step;
    sms_pkg::t_root   sq_res_step;
    logic [2*sms_pkg::COUNT_W-1:0] nn1;
    logic [SW-1:0]    q_lo;

    assign sum_neg = r_set.sum[sms_pkg::SUM_W-1];
    assign abs_sum = sum_neg ? sms_pkg::t_mag'(-r_set.sum) : sms_pkg::t_mag'(r_set.sum);

    // shift-add multiplier step
    assign mul_sum      = r_mul_acc + r_mul_a;
    assign mul_acc_step = r_mul_b[0] ? mul_sum : r_mul_acc;

    // restoring divider step, one quotient bit per cycle
    assign rem_sh       = {r_div_rem, r_div_quo[WW-1]};
    assign rem_diff     = rem_sh - {1'b0, r_divisor};
    assign div_ge       = rem_sh >= {1'b0, r_divisor};
    assign div_rem_step = div_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
    assign div_quo_step = {r_div_quo[WW-2:0], div_ge};

    // square root step, one result bit per cycle
    assign sq_trial    = r_sq_res + r_sq_bit;
    assign sq_ge       = r_sq_v >= sq_trial;
    assign sq_v_step   = sq_ge ? r_sq_v - sq_trial : r_sq_v;
    assign sq_res_step = sq_ge ? (r_sq_res >> 1) + r_sq_bit : r_sq_res >> 1;

    assign nn1  = r_set.count * (r_set.count - 1'b1);
    assign q_lo = div_quo_step[SW-1:0];

    // sequencer: next state, datapath and handshake
    always_comb begin
        n_state     = r_state;
        n_set       = r_set;
        n_step      = r_step;
        n_mul_acc   = r_mul_acc;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_nq        = r_nq;
        n_div_rem   = r_div_rem;
        n_div_quo   = r_div_quo;
        n_divisor   = r_divisor;
        n_sq_v      = r_sq_v;
        n_sq_res    = r_sq_res;
        n_sq_bit    = r_sq_bit;
        n_sd        = r_sd;
        n_mean      = r_mean;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        n_out_valid = r_out_valid & ~o_out.ready;

        unique case (r_state)
            sms_pkg::BK_IDLE: begin
                o_pop = i_head_valid;
                if (i_head_valid) begin
                    n_set     = i_head;
                    n_mul_acc = '0;
                    n_mul_a   = sms_pkg::t_wide'(i_head.sq_sum);
                    n_mul_b   = sms_pkg::t_mag'(i_head.count);
                    n_step    = '0;
                    n_sd      = '0;
                    n_mean    = '0;
                    if (i_head.count == '0) begin
                        n_state = sms_pkg::BK_FINISH;
                    end else if (i_head.count == sms_pkg::t_count'(1)) begin
                        n_state = sms_pkg::BK_MEAN_SETUP;
                    end else begin
                        n_state = sms_pkg::BK_MUL_NQ;
                    end
                end
            end
            sms_pkg::BK_MUL_NQ: begin
                n_mul_acc = mul_acc_step;
                n_mul_a   = r_mul_a << 1;
                n_mul_b   = r_mul_b >> 1;
                n_step    = r_step + 1'b1;
                if (r_step == MUL_END) begin
                    n_nq      = mul_acc_step;
                    n_mul_acc = '0;
                    n_mul_a   = sms_pkg::t_wide'(abs_sum);
                    n_mul_b   = abs_sum;
                    n_step    = '0;
                    n_state   = sms_pkg::BK_MUL_SS;
                end
            end
            sms_pkg::BK_MUL_SS: begin
                n_mul_acc = mul_acc_step;
                n_mul_a   = r_mul_a << 1;
                n_mul_b   = r_mul_b >> 1;
                n_step    = r_step + 1'b1;
                if (r_step == MUL_END) begin
                    n_step  = '0;
                    n_state = sms_pkg::BK_SUB;
                end
            end
            sms_pkg::BK_SUB: begin
                // numerator n*Q - S*S, clamped at zero
                n_div_quo = (r_nq >= r_mul_acc) ? r_nq - r_mul_acc : '0;
                n_div_rem = '0;
                n_divisor = nn1[DW-1:0];
                n_step    = '0;
                n_state   = sms_pkg::BK_DIV_VAR;
            end
            sms_pkg::BK_DIV_VAR: begin
                n_div_rem = div_rem_step;
                n_div_quo = div_quo_step;
                n_step    = r_step + 1'b1;
                if (r_step == DIV_END) begin
                    n_sq_v   = (|div_quo_step[WW-1:RW]) ? '1 : div_quo_step[RW-1:0];
                    n_sq_res = '0;
                    n_sq_bit = sms_pkg::SQRT_TOP;
                    n_step   = '0;
                    n_state  = sms_pkg::BK_SQRT;
                end
            end
            sms_pkg::BK_SQRT: begin
                n_sq_v   = sq_v_step;
                n_sq_res = sq_res_step;
                n_sq_bit = r_sq_bit >> 2;
                n_step   = r_step + 1'b1;
                if (r_step == SQRT_END) begin
                    n_sd    = (|sq_res_step[RW-1:SW]) ? '1 : sq_res_step[SW-1:0];
                    n_step  = '0;
                    n_state = sms_pkg::BK_MEAN_SETUP;
                end
            end
            sms_pkg::BK_MEAN_SETUP: begin
                n_div_quo = sms_pkg::t_wide'(abs_sum);
                n_div_rem = '0;
                n_divisor = sms_pkg::t_divisor'(r_set.count);
                n_step    = '0;
                n_state   = sms_pkg::BK_DIV_MEAN;
            end
            sms_pkg::BK_DIV_MEAN: begin
                n_div_rem = div_rem_step;
                n_div_quo = div_quo_step;
                n_step    = r_step + 1'b1;
                if (r_step == DIV_END) begin
                    // truncation toward zero: divide magnitude, restore sign
                    n_mean  = sms_pkg::t_sample'(sum_neg ? (~q_lo + 1'b1) : q_lo);
                    n_step  = '0;
                    n_state = sms_pkg::BK_FINISH;
                end
            end
            sms_pkg::BK_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = sms_pkg::BK_IDLE;
                end
            end
            default: n_state = sms_pkg::BK_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sms_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath and output registers
    always_ff @(posedge i_clk) begin
        r_set     <= n_set;
        r_step    <= n_step;
        r_mul_acc <= n_mul_acc;
        r_mul_a   <= n_mul_a;
        r_mul_b   <= n_mul_b;
        r_nq      <= n_nq;
        r_div_rem <= n_div_rem;
        r_div_quo <= n_div_quo;
        r_divisor <= n_divisor;
        r_sq_v    <= n_sq_v;
        r_sq_res  <= n_sq_res;
        r_sq_bit  <= n_sq_bit;
        r_sd      <= n_sd;
        r_mean    <= n_mean;
        if (load_out) begin
            out_count <= r_set.count;
            out_mean  <= r_mean;
            out_sd    <= r_sd;
            out_max   <= r_set.maximum;
            out_min   <= r_set.minimum;
            out_ovf   <= r_set.overflow;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.count    = out_count;
    assign o_out.mean     = out_mean;
    assign o_out.std_dev  = out_sd;
    assign o_out.maximum  = out_max;
    assign o_out.minimum  = out_min;
    assign o_out.overflow = out_ovf;

endmodule
`default_nettype wire

FILE: hw/rtl/set_mean_stddev_min_max.sv
// Top level of the set statistics block: front end, queue and back end.
// Depends on sms_pkg, sms_in_if, sms_out_if, sms_front, sms_queue, sms_back.
//
//   port   | dir | payload                                          | role
//   -------+-----+--------------------------------------------------+-----------------
//   i_in   | in  | sample, has_value, last                          | one item/transfer
//   o_out  | out | count, mean, std_dev, maximum, minimum, overflow | one result per set
//
// The front end takes one item every cycle while its ready is high; its running totals are registered per item.
// A closed set is handed to a two-entry queue; the front end stalls only when that
// queue would overflow. The back end takes one set at a time; for two or more samples it runs
// 36+36 multiplier steps, 72 divider steps, 32 root steps and 72 mean divider steps, for
// one sample only the mean divider steps, and an empty set goes straight to the result.
// Reset is synchronous, active low, and clears all totals and the queue.
`default_nettype none
module set_mean_stddev_min_max #(
    parameter int unsigned MAX_COUNT = sms_pkg::MAX_COUNT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sms_in_if.sink    i_in,
    sms_out_if.source o_out
);

    sms_pkg::t_push     push;
    sms_pkg::t_set_sums head;
    logic               head_valid;
    logic               pop;
    sms_pkg::t_level    q_level;

    sms_front #(
        .MAX_COUNT (MAX_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_level (q_level),
        .o_push    (push)
    );

    sms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_level      (q_level)
    );

    sms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // a closed set never lands on a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> (q_level < sms_pkg::t_level'(sms_pkg::Q_DEPTH)))
        else $error("push into full queue");

    // fewer than two samples give zero deviation
    a_sd_small_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.count < sms_pkg::t_count'(2))) |-> (o_out.std_dev == '0))
        else $error("nonzero deviation for small set");

    // an empty set reports all zero
    a_empty_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.count == '0)) |->
        ((o_out.mean == '0) && (o_out.maximum == '0) && (o_out.minimum == '0)
         && !o_out.overflow))
        else $error("empty set with nonzero fields");

    // overflow only with a saturated count
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |->
        (o_out.count == sms_pkg::t_count'(MAX_COUNT)))
        else $error("overflow without saturated count");

endmodule
`default_nettype wire

FILE: tb/tb_set_mean_stddev_min_max.sv
// Testbench for set_mean_stddev_min_max: random and directed sample sets, checked
// against a bit-exact model of count, mean, deviation, max, min and overflow.
// Depends on sms_pkg, sms_in_if, sms_out_if and the block under test.
`default_nettype none
module tb_set_mean_stddev_min_max;

    localparam int STALL_LIMIT = 4000;   // cycles without any transfer
    localparam int TAIL_CYCLES = 300;    // wait for the back end after the last test
    localparam sms_pkg::t_sample SMP_MIN = {1'b1, {(sms_pkg::SAMPLE_W-1){1'b0}}};
    localparam sms_pkg::t_sample SMP_MAX = {1'b0, {(sms_pkg::SAMPLE_W-1){1'b1}}};

    typedef struct packed {
        sms_pkg::t_count  count;
        sms_pkg::t_sample mean;
        sms_pkg::t_udev   std_dev;
        sms_pkg::t_sample maximum;
        sms_pkg::t_sample minimum;
        logic             overflow;
    } t_set_stats;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sms_in_if  in_bus();
    sms_out_if out_bus();

    set_mean_stddev_min_max i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Clock, period 20
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Running totals of the open set, as the block should hold them
    sms_pkg::t_count  tot_count;
    sms_pkg::t_sum    tot_sum;
    sms_pkg::t_sqsum  tot_sqsum;
    sms_pkg::t_sample tot_max;
    sms_pkg::t_sample tot_min;
    logic             tot_ovf;

    t_set_stats stats_due[$];

    int errors        = 0;
    int items_total   = 0;
    int sets_checked  = 0;
    int empty_sets    = 0;
    int sat_sets      = 0;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int stall_cycles  = 0;

    // Fold one accepted item into the totals; returns 1 with the set's statistics
    // when the item closes the set.
    function automatic logic fold_into_totals(input sms_pkg::t_sample s, input logic hv,
                                              input logic lst, output t_set_stats res);
        logic signed [sms_pkg::SQSUM_W-1:0] sx;
        logic signed [sms_pkg::SUM_W+4:0]   num_s, den_s, quo;
        sms_pkg::t_mag                      smag;
        logic [127:0]                       nq, ss, num, q;
        logic [63:0]                        v;
        logic [31:0]                        r, trial;
        int                                 b;
        res = '0;
        if (hv) begin
            if (tot_count >= sms_pkg::MAX_COUNT) begin
                // saturated: the sample is dropped entirely
                tot_ovf = 1'b1;
            end else begin
                if (tot_count == 0) begin
                    tot_max = s;
                    tot_min = s;
                end else begin
                    if (s > tot_max) tot_max = s;
                    if (s < tot_min) tot_min = s;
                end
                sx        = {{(sms_pkg::SQSUM_W-sms_pkg::SAMPLE_W){s[sms_pkg::SAMPLE_W-1]}}, s};
                tot_sum   = tot_sum + sms_pkg::t_sum'(s);
                tot_sqsum = tot_sqsum + sms_pkg::t_sqsum'(sx * sx);
                tot_count = tot_count + 1'b1;
            end
        end
        if (!lst) return 1'b0;

        res.count    = tot_count;
        res.maximum  = tot_max;
        res.minimum  = tot_min;
        res.overflow = tot_ovf;
        // mean truncates toward zero
        if (tot_count != 0) begin
            num_s    = tot_sum;
            den_s    = {28'd0, tot_count};
            quo      = num_s / den_s;
            res.mean = quo[sms_pkg::SAMPLE_W-1:0];
        end
        // deviation: floor(sqrt((n*Q - S*S) / (n*(n-1)))), numerator clamped at zero
        if (tot_count > 1) begin
            smag = (tot_sum < 0) ? sms_pkg::t_mag'(-tot_sum) : sms_pkg::t_mag'(tot_sum);
            nq   = 128'(tot_count) * 128'(tot_sqsum);
            ss   = 128'(smag) * 128'(smag);
            num  = (nq > ss) ? nq - ss : '0;
            q    = num / (128'(tot_count) * (128'(tot_count) - 128'd1));
            v    = (q[127:64] != 0) ? '1 : q[63:0];
            r    = '0;
            for (b = 31; b >= 0; b--) begin
                trial = r | (32'd1 << b);
                if (64'(trial) * 64'(trial) <= v) r = trial;
            end
            res.std_dev = (r > 32'hFF_FFFF) ? '1 : r[sms_pkg::SAMPLE_W-1:0];
        end
        if (tot_count == 0) empty_sets++;
        if (tot_ovf) sat_sets++;
        tot_count = '0;
        tot_sum   = '0;
        tot_sqsum = '0;
        tot_max   = '0;
        tot_min   = '0;
        tot_ovf   = 1'b0;
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("set %0d: %s got %0h, expected %0h",
                                 sets_checked, name, got, want));
    endtask

    // Send one item; the predictor runs at the edge of its transfer
    task automatic push_item(input sms_pkg::t_sample s, input logic hv, input logic lst);
        t_set_stats res;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid     = 1'b1;
        in_bus.sample    = s;
        in_bus.has_value = hv;
        in_bus.last      = lst;
        do @(posedge i_clk); while (!in_bus.ready);
        if (fold_into_totals(s, hv, lst, res)) stats_due.push_back(res);
        items_total++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_bus.valid     = 1'b0;
        in_bus.has_value = 1'b0;
        in_bus.last      = 1'b0;
        while (stats_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic sms_pkg::t_sample pick_sample(input int style,
                                                     input sms_pkg::t_sample base);
        case (style)
            0: return sms_pkg::t_sample'($urandom);
            1: case ($urandom_range(4))
                   0: return SMP_MIN;
                   1: return SMP_MAX;
                   2: return sms_pkg::t_sample'(0);
                   3: return sms_pkg::t_sample'(-1);
                   default: return sms_pkg::t_sample'(1);
               endcase
            2: return sms_pkg::t_sample'(base + sms_pkg::t_sample'($urandom_range(8191))
                                         - sms_pkg::t_sample'(4096));
            default: return base;
        endcase
    endfunction

    // Extremes and the special cases, one set each
    task automatic test_directed();
        push_item(SMP_MIN, 1'b1, 1'b1);                  // single sample, most negative
        push_item(SMP_MAX, 1'b1, 1'b1);                  // single sample, most positive
        push_item(sms_pkg::t_sample'($urandom), 1'b0, 1'b1);      // empty set
        push_item(SMP_MAX, 1'b1, 1'b0);                  // widest spread, closed without value
        push_item(SMP_MIN, 1'b1, 1'b0);
        push_item(sms_pkg::t_sample'($urandom), 1'b0, 1'b1);
        push_item(sms_pkg::t_sample'(24'h5A_5A5A), 1'b0, 1'b0);   // idle item between sets
        push_item(sms_pkg::t_sample'(-3), 1'b1, 1'b0);   // negative mean truncates toward zero
        push_item(sms_pkg::t_sample'(24'hA5_A5A5), 1'b0, 1'b0);   // idle item inside a set
        push_item(sms_pkg::t_sample'(-4), 1'b1, 1'b1);
        repeat (3) push_item(sms_pkg::t_sample'(4096), 1'b1, 1'b0); // zero variance
        push_item(sms_pkg::t_sample'(4096), 1'b1, 1'b1);
        push_item(sms_pkg::t_sample'(-1), 1'b1, 1'b0);   // mean of zero
        push_item(sms_pkg::t_sample'(1), 1'b1, 1'b1);
        push_item(SMP_MIN, 1'b1, 1'b0);                  // constant at the negative extreme
        push_item(SMP_MIN, 1'b1, 1'b0);
        push_item(sms_pkg::t_sample'(24'hFF_FFFF), 1'b0, 1'b1);
        drain_results();
    endtask

    // Exactly MAX_COUNT samples, then a set that runs past the count
    task automatic test_count_saturation();
        int i;
        for (i = 0; i < sms_pkg::MAX_COUNT; i++)
            push_item(sms_pkg::t_sample'($urandom), 1'b1, i == sms_pkg::MAX_COUNT - 1);
        for (i = 0; i < sms_pkg::MAX_COUNT; i++)
            push_item(SMP_MIN, 1'b1, 1'b0);
        push_item(sms_pkg::t_sample'($urandom), 1'b1, 1'b0);
        push_item(SMP_MAX, 1'b1, 1'b0);
        push_item(sms_pkg::t_sample'($urandom), 1'b1, 1'b1);
        push_item(SMP_MAX, 1'b1, 1'b1);                  // totals start clean afterwards
        drain_results();
    endtask

    // Well-formed sets of random size and content, with idle items as noise
    task automatic test_random_sets(input int target);
        int               sent, size, style, k, i;
        sms_pkg::t_sample base;
        logic             tail_close;
        sent = 0;
        while (sent < target) begin
            k          = $urandom_range(99);
            size       = (k < 12) ? 0 : (k < 92) ? $urandom_range(8, 1) : $urandom_range(64, 9);
            style      = $urandom_range(3);
            base       = sms_pkg::t_sample'($urandom);
            tail_close = (size == 0) || $urandom_range(1);
            for (i = 0; i < size; i++) begin
                if ($urandom_range(9) == 0)
                    push_item(sms_pkg::t_sample'($urandom), 1'b0, 1'b0);
                push_item(pick_sample(style, base), 1'b1, !tail_close && (i == size - 1));
                sent++;
            end
            if (tail_close) begin
                push_item(sms_pkg::t_sample'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
        drain_results();
    endtask

    // Result receiver: ready changes at the falling edge
    always @(negedge i_clk) begin
        out_bus.ready = ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare each result transfer with the oldest pending set
    always @(posedge i_clk) begin : result_check
        t_set_stats want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (stats_due.size() == 0) begin
                flag_error("result transfer with no closed set pending");
            end else begin
                want = stats_due.pop_front();
                check_field("count",    64'(out_bus.count),    64'(want.count));
                check_field("mean",     64'(out_bus.mean),     64'(want.mean));
                check_field("std_dev",  64'(out_bus.std_dev),  64'(want.std_dev));
                check_field("maximum",  64'(out_bus.maximum),  64'(want.maximum));
                check_field("minimum",  64'(out_bus.minimum),  64'(want.minimum));
                check_field("overflow", 64'(out_bus.overflow), 64'(want.overflow));
                sets_checked++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d sets pending",
                     STALL_LIMIT, stats_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sequence of tests
    initial begin
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.sample    = '0;
        in_bus.has_value = 1'b0;
        in_bus.last      = 1'b0;
        out_bus.ready    = 1'b0;
        tot_count        = '0;
        tot_sum          = '0;
        tot_sqsum        = '0;
        tot_max          = '0;
        tot_min          = '0;
        tot_ovf          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct = 15;
        snk_idle_pct = 66;
        test_directed();
        test_random_sets(580);

        src_idle_pct = 66;
        snk_idle_pct = 15;
        test_random_sets(580);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_count_saturation();
        test_random_sets(590);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (stats_due.size() != 0)
            flag_error($sformatf("%0d closed sets never produced a result", stats_due.size()));

        $display("Checked %0d set results from %0d items (%0d empty, %0d saturated sets).",
                 sets_checked, items_total, empty_sets, sat_sets);
        $display("Sender/receiver idle mixes 15/66, 66/15 and none; count limit %0d.",
                 sms_pkg::MAX_COUNT);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
